### rtl/trsn_pkg.sv
package trsn_pkg;

  localparam int CPW    = 21;
  localparam int STAGES = 3;
  localparam int SIW    = (STAGES > 1) ? $clog2(STAGES) : 1;

  localparam logic [CPW-1:0] SPACE_CP = CPW'(32'h20);
  localparam logic [CPW-1:0] APOS_CP  = CPW'(32'h27);
  localparam logic [CPW-1:0] DIGIT_LO = CPW'(32'h30);
  localparam logic [CPW-1:0] DIGIT_HI = CPW'(32'h39);

  typedef enum logic [1:0] {
    REG_REP_EN   = 2'd0,
    REG_MASK_LO  = 2'd1,
    REG_MASK_HI  = 2'd2,
    REG_MAX_CHAR = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    EM_NONE     = 2'd0,
    EM_SHIFT    = 2'd1,
    EM_CONTRACT = 2'd2,
    EM_FLUSH    = 2'd3
  } emit_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_FINAL = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic           push;
    logic           push_rep;
    logic [CPW-1:0] push_cp;
    logic           flush_en;
    logic [SIW-1:0] flush_idx;
    logic           final_flush;
  } dp_cmd_t;

endpackage

### rtl/trsn_ctrl.sv
module trsn_ctrl
  import trsn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [CPW-1:0] in_code_point,
  input  logic           in_end_of_string,
  input  logic           rep_en,
  input  logic [15:0]    max_chars,
  input  logic           busy,
  output dp_cmd_t        cmd
);

  ctrl_state_t    state_r, state_nxt;
  logic [SIW-1:0] idx_r, idx_nxt;
  logic [15:0]    kept_r, kept_nxt;
  logic           open_r, open_nxt;
  logic           rep_r, rep_nxt;
  logic           accept;
  logic           rep_now;

  assign in_stall = !((state_r == ST_IDLE) && !busy);
  assign accept   = in_valid && !in_stall;
  assign rep_now  = open_r ? rep_r : rep_en;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    kept_nxt  = kept_r;
    open_nxt  = open_r;
    rep_nxt   = rep_r;
    cmd       = '0;
    cmd.push_cp  = in_code_point;
    cmd.push_rep = rep_now;
    cmd.flush_idx = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          open_nxt = 1'b1;
          rep_nxt  = rep_now;
          if (kept_r < max_chars) begin
            kept_nxt = kept_r + 16'd1;
            cmd.push = 1'b1;
          end
          if (in_end_of_string) begin
            idx_nxt   = '0;
            state_nxt = rep_now ? ST_FLUSH : ST_FINAL;
          end
        end
      end
      ST_FLUSH: begin
        if (!busy) begin
          cmd.flush_en = 1'b1;
          if (idx_r == SIW'(STAGES - 1)) begin
            state_nxt = ST_FINAL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (!busy) begin
          cmd.final_flush = 1'b1;
          kept_nxt  = '0;
          open_nxt  = 1'b0;
          rep_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      kept_r  <= '0;
      open_r  <= 1'b0;
      rep_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      kept_r  <= kept_nxt;
      open_r  <= open_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule

### rtl/trsn_sep.sv
module trsn_sep
  import trsn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rx_v,
  input  logic [CPW-1:0] rx_c,
  input  logic           final_flush,
  input  logic [63:0]    mask_low,
  input  logic [63:0]    mask_high,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CPW-1:0] out_code_point,
  output logic           out_last
);

  logic [CPW-1:0] held_r, held_nxt;
  logic           held_v_r, held_v_nxt;
  logic           prev_sp_r, prev_sp_nxt;
  logic           seen_r, seen_nxt;
  logic           last_sp_r, last_sp_nxt;
  logic [CPW-1:0] rel_r, rel_nxt;
  logic           rel_last_r, rel_last_nxt;
  logic           pre_r, pre_nxt;
  logic           chr_r, chr_nxt;
  logic           post_r, post_nxt;
  logic           do_rel;
  logic           next_ns;
  logic           rel_end;
  logic           is_sep;

  // Space is never a separator, and nothing past ASCII is one.
  always_comb begin
    is_sep = 1'b0;
    if (held_r == SPACE_CP) begin
      is_sep = 1'b0;
    end else if (held_r < CPW'(64)) begin
      is_sep = mask_low[held_r[5:0]];
    end else if (held_r < CPW'(128)) begin
      is_sep = mask_high[held_r[5:0]];
    end
  end

  assign busy           = pre_r | chr_r | post_r;
  assign out_valid      = busy;
  assign out_code_point = (!pre_r && chr_r) ? rel_r : SPACE_CP;
  assign out_last       = !pre_r && chr_r && rel_last_r;

  always_comb begin
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    prev_sp_nxt  = prev_sp_r;
    seen_nxt     = seen_r;
    last_sp_nxt  = last_sp_r;
    rel_nxt      = rel_r;
    rel_last_nxt = rel_last_r;
    pre_nxt      = pre_r;
    chr_nxt      = chr_r;
    post_nxt     = post_r;
    do_rel       = held_v_r && (rx_v || final_flush);
    next_ns      = rx_v && (rx_c != SPACE_CP);
    rel_end      = final_flush;

    if (out_valid && !out_stall) begin
      if (pre_r) begin
        pre_nxt = 1'b0;
      end else if (chr_r) begin
        chr_nxt = 1'b0;
      end else begin
        post_nxt = 1'b0;
      end
    end

    if (do_rel) begin
      pre_nxt      = is_sep && seen_r && !prev_sp_r && !last_sp_r;
      chr_nxt      = 1'b1;
      post_nxt     = is_sep && next_ns && (held_r != APOS_CP);
      rel_nxt      = held_r;
      rel_last_nxt = rel_end;
      last_sp_nxt  = (is_sep && next_ns && (held_r != APOS_CP)) || (held_r == SPACE_CP);
      prev_sp_nxt  = (held_r == SPACE_CP);
      seen_nxt     = 1'b1;
      held_v_nxt   = 1'b0;
    end

    if (rx_v) begin
      held_nxt   = rx_c;
      held_v_nxt = 1'b1;
    end

    if (final_flush) begin
      held_v_nxt  = 1'b0;
      prev_sp_nxt = 1'b0;
      seen_nxt    = 1'b0;
      last_sp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r  <= 1'b0;
      prev_sp_r <= 1'b0;
      seen_r    <= 1'b0;
      last_sp_r <= 1'b0;
      pre_r     <= 1'b0;
      chr_r     <= 1'b0;
      post_r    <= 1'b0;
    end else begin
      held_v_r  <= held_v_nxt;
      prev_sp_r <= prev_sp_nxt;
      seen_r    <= seen_nxt;
      last_sp_r <= last_sp_nxt;
      pre_r     <= pre_nxt;
      chr_r     <= chr_nxt;
      post_r    <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    rel_r      <= rel_nxt;
    rel_last_r <= rel_last_nxt;
  end

endmodule

### rtl/trsn_datapath.sv
module trsn_datapath
  import trsn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  input  logic [63:0]    mask_low,
  input  logic [63:0]    mask_high,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CPW-1:0] out_code_point,
  output logic           out_last
);

  logic [STAGES-1:0] em_v;
  logic [CPW-1:0]    em_c [STAGES];
  logic [STAGES-1:0] take;
  logic              sep_busy;
  logic              sep_rx_v;
  logic [CPW-1:0]    sep_rx_c;

  // The deepest stage with a character to hand on moves first, so each stage
  // sees its characters in order and no queue is needed between stages.
  always_comb begin
    logic any;
    any = sep_busy;
    for (int s = STAGES - 1; s >= 0; s--) begin
      take[s] = em_v[s] && !any;
      any     = any || em_v[s];
    end
  end

  assign busy = sep_busy || (|em_v);

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int N  = s + 1;
    localparam int IW = $clog2(3 * N);
    localparam int FW = $clog2(3 * N + 1);
    localparam logic [FW-1:0] N1 = FW'(N);
    localparam logic [FW-1:0] N2 = FW'(2 * N);
    localparam logic [FW-1:0] N3 = FW'(3 * N);

    logic [CPW-1:0] win_r [3*N];
    logic [CPW-1:0] win_nxt [3*N];
    logic [CPW-1:0] wtmp [3*N];
    logic [FW-1:0]  fill_r, fill_nxt;
    logic [FW-1:0]  ptr_r, ptr_nxt;
    logic [FW-1:0]  end_r, end_nxt;
    logic           skip_r, skip_nxt;
    emit_mode_t     mode_r, mode_nxt;
    logic           rx_v;
    logic [CPW-1:0] rx_c;
    logic           do_flush;
    logic           eq1, eq2, clean;
    logic [FW-1:0]  fill_inc;
    logic [FW-1:0]  ptr_inc;

    if (s == 0) begin : g_first
      assign rx_v = cmd.push && cmd.push_rep;
      assign rx_c = cmd.push_cp;
    end else begin : g_next
      assign rx_v = take[s-1];
      assign rx_c = em_c[s-1];
    end

    assign do_flush = cmd.flush_en && (cmd.flush_idx == SIW'(s));
    assign em_v[s]  = (mode_r != EM_NONE);
    assign em_c[s]  = win_r[ptr_r[IW-1:0]];
    assign fill_inc = fill_r + 1'b1;
    assign ptr_inc  = ptr_r + 1'b1;

    always_comb begin
      wtmp = win_r;
      if (rx_v) begin
        wtmp[fill_r[IW-1:0]] = rx_c;
      end
      eq1   = 1'b1;
      eq2   = 1'b1;
      clean = 1'b1;
      for (int k = 0; k < N; k++) begin
        if (wtmp[k] != wtmp[k+N]) eq1 = 1'b0;
        if (wtmp[k] != wtmp[k+2*N]) eq2 = 1'b0;
        if ((wtmp[k] == SPACE_CP) || ((wtmp[k] >= DIGIT_LO) && (wtmp[k] <= DIGIT_HI))) begin
          clean = 1'b0;
        end
      end
    end

    always_comb begin
      win_nxt  = win_r;
      fill_nxt = fill_r;
      ptr_nxt  = ptr_r;
      end_nxt  = end_r;
      skip_nxt = skip_r;
      mode_nxt = mode_r;

      if (take[s]) begin
        ptr_nxt = ptr_inc;
        if (ptr_inc == end_r) begin
          mode_nxt = EM_NONE;
          case (mode_r)
            EM_SHIFT: begin
              for (int k = 0; k < 3 * N - 1; k++) begin
                win_nxt[k] = win_r[k+1];
              end
              fill_nxt = N3 - 1'b1;
            end
            EM_FLUSH: begin
              fill_nxt = '0;
              skip_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      if (rx_v) begin
        win_nxt = wtmp;
        if (skip_r) begin
          fill_nxt = fill_inc;
          if (fill_inc == N2) begin
            fill_nxt = N1;
            if (!eq1) begin
              for (int k = 0; k < N; k++) begin
                win_nxt[k] = wtmp[k+N];
              end
              skip_nxt = 1'b0;
            end
          end
        end else if (fill_inc < N3) begin
          fill_nxt = fill_inc;
        end else if (clean && eq1 && eq2) begin
          // Clean pattern seen three times: pass two copies, then drop repeats.
          fill_nxt = N1;
          skip_nxt = 1'b1;
          mode_nxt = EM_CONTRACT;
          ptr_nxt  = '0;
          end_nxt  = N2;
        end else begin
          fill_nxt = N3;
          mode_nxt = EM_SHIFT;
          ptr_nxt  = '0;
          end_nxt  = FW'(1);
        end
      end

      if (do_flush) begin
        if ((skip_r ? N1 : FW'(0)) < fill_r) begin
          mode_nxt = EM_FLUSH;
          ptr_nxt  = skip_r ? N1 : FW'(0);
          end_nxt  = fill_r;
        end else begin
          fill_nxt = '0;
          skip_nxt = 1'b0;
        end
      end

      if (cmd.final_flush) begin
        fill_nxt = '0;
        skip_nxt = 1'b0;
        mode_nxt = EM_NONE;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fill_r <= '0;
        skip_r <= 1'b0;
        mode_r <= EM_NONE;
      end else begin
        fill_r <= fill_nxt;
        skip_r <= skip_nxt;
        mode_r <= mode_nxt;
      end
    end

    always_ff @(posedge clk) begin
      win_r <= win_nxt;
      ptr_r <= ptr_nxt;
      end_r <= end_nxt;
    end
  end

  assign sep_rx_v = take[STAGES-1] || (cmd.push && !cmd.push_rep);
  assign sep_rx_c = take[STAGES-1] ? em_c[STAGES-1] : cmd.push_cp;

  trsn_sep u_sep (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_v           (sep_rx_v),
    .rx_c           (sep_rx_c),
    .final_flush    (cmd.final_flush),
    .mask_low       (mask_low),
    .mask_high      (mask_high),
    .busy           (sep_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_last       (out_last)
  );

endmodule

### rtl/text_repetition_separator_normalizer.sv
// A character moves on only when later characters or the end-of-string flush push it out of
// the windows; for a lone character that ends a string, the controller flushes each stage in
// turn when contraction is on, then releases the held character. An item is taken only when
// the datapath is quiet, so the block takes no new character while hand-offs or result items
// are pending; one hand-off or one result item moves per cycle, result items only while the
// result channel does not stall. Reset (rst_n low, sync.)
module text_repetition_separator_normalizer
  import trsn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  // Input channel: one code point per item.
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [CPW-1:0] in_code_point,
  input  logic           in_end_of_string,
  // Result channel.
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CPW-1:0] out_code_point,
  output logic           out_last,
  // Configuration port, 64-bit registers at 8-byte spacing.
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);

  // Reset loads the register defaults and empties every stage.

  // Configuration registers. The enable is sampled by the controller at the
  // first item of a string; the masks and the length limit act at once.
  logic        rep_en_r;
  logic [63:0] mask_lo_r;
  logic [63:0] mask_hi_r;
  logic [15:0] max_chars_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  dp_cmd_t     cmd;
  logic        dp_busy;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_en_r    <= 1'b1;
      mask_lo_r   <= '0;
      mask_hi_r   <= '0;
      max_chars_r <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_REP_EN:   rep_en_r    <= pwdata[0];
        REG_MASK_LO:  mask_lo_r   <= pwdata;
        REG_MASK_HI:  mask_hi_r   <= pwdata;
        REG_MAX_CHAR: max_chars_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REP_EN:   prdata = {63'd0, rep_en_r};
      REG_MASK_LO:  prdata = mask_lo_r;
      REG_MASK_HI:  prdata = mask_hi_r;
      REG_MAX_CHAR: prdata = {48'd0, max_chars_r};
      default:      prdata = '0;
    endcase
  end

  // The controller takes an item only when the whole datapath is quiet, counts
  // kept characters against the limit and sequences the end-of-string flush: each
  // contraction stage in turn if enabled, then the separator stage's held character.
  trsn_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_point    (in_code_point),
    .in_end_of_string (in_end_of_string),
    .rep_en           (rep_en_r),
    .max_chars        (max_chars_r),
    .busy             (dp_busy),
    .cmd              (cmd)
  );

  // The datapath holds the look-ahead windows of the contraction stages and
  // the separator stage, whose pending result items sit in registers that
  // drive the result channel directly.
  trsn_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .mask_low       (mask_lo_r),
    .mask_high      (mask_hi_r),
    .busy           (dp_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_last       (out_last)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  import trsn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Block ports. Every input starts at a known value.
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [CPW-1:0] in_code_point = '0;
  logic           in_end_of_string = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [CPW-1:0] out_code_point;
  logic           out_last;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [4:0]     paddr = '0;
  logic [63:0]    pwdata = '0;
  logic [63:0]    prdata;
  logic           pready;

  text_repetition_separator_normalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_code_point(in_code_point), .in_end_of_string(in_end_of_string),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_point(out_code_point), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // One character of an input string, as the driver presents it.
  typedef struct {
    logic [CPW-1:0] cp;
    logic           eos;
  } char_item_t;

  char_item_t     pending_chars[$];
  logic [CPW-1:0] expected_cp[$];
  logic           expected_last[$];
  int             error_count = 0;
  // While calm is set neither side idles, so back-to-back traffic is covered.
  bit             calm = 1'b0;
  int unsigned    cycle_count = 0;

  // Shadow copy of the configuration registers.
  logic        rep_enable_q = 1'b1;
  logic [63:0] sep_mask_lo_q = '0;
  logic [63:0] sep_mask_hi_q = '0;
  logic [15:0] max_chars_q = 16'hFFFF;

  // Per-string state of the normalizer as predicted. Windows are indexed by
  // stage; stage s holds up to 3*(s+1) characters.
  int unsigned    kept_chars;
  logic [CPW-1:0] stage_win[STAGES][9];
  bit             stage_skipping[STAGES];
  int             stage_fill[STAGES];
  logic [CPW-1:0] held_cp;
  bit             held_ok;
  bit             held_after_space;
  bit             passed_any;
  bit             wrote_space;
  bit             rep_latched;
  bit             string_open;

  function automatic void clear_string_state();
    for (int s = 0; s < STAGES; s++) begin
      stage_skipping[s] = 1'b0;
      stage_fill[s] = 0;
    end
    kept_chars = 0;
    held_cp = '0;
    held_ok = 1'b0;
    held_after_space = 1'b0;
    passed_any = 1'b0;
    wrote_space = 1'b0;
    rep_latched = 1'b0;
    string_open = 1'b0;
  endfunction

  function automatic bit is_separator(logic [CPW-1:0] c);
    if (c == SPACE_CP) return 1'b0;
    if (c < 64) return sep_mask_lo_q[c[5:0]];
    if (c < 128) return sep_mask_hi_q[c[5:0]];
    return 1'b0;
  endfunction

  function automatic void expect_char(logic [CPW-1:0] c, logic last);
    expected_cp.push_back(c);
    expected_last.push_back(last);
  endfunction

  // Writes the held character, with a space around it when it is a separator.
  function automatic void release_held(bit next_nonspace, bit last);
    bit sep;
    sep = is_separator(held_cp);
    if (sep && passed_any && !held_after_space && !wrote_space)
      expect_char(SPACE_CP, 1'b0);
    expect_char(held_cp, last);
    wrote_space = (held_cp == SPACE_CP);
    if (sep && next_nonspace && held_cp != APOS_CP) begin
      expect_char(SPACE_CP, 1'b0);
      wrote_space = 1'b1;
    end
    held_after_space = (held_cp == SPACE_CP);
    passed_any = 1'b1;
    held_ok = 1'b0;
  endfunction

  function automatic void separator_feed(logic [CPW-1:0] c);
    if (held_ok) release_held(c != SPACE_CP, 1'b0);
    held_cp = c;
    held_ok = 1'b1;
  endfunction

  // Contraction stage s works on patterns of s+1 characters. A clean pattern
  // seen three times in a row is passed twice, and further copies are dropped.
  function automatic void stage_feed(int s, logic [CPW-1:0] c);
    int n, f;
    bit clean, same;
    logic [CPW-1:0] x;
    if (s >= STAGES) begin
      separator_feed(c);
      return;
    end
    n = s + 1;
    f = stage_fill[s];
    stage_win[s][f] = c;
    f++;
    if (stage_skipping[s]) begin
      if (f == 2 * n) begin
        same = 1'b1;
        for (int k = 0; k < n; k++)
          if (stage_win[s][k] != stage_win[s][n + k]) same = 1'b0;
        if (!same) begin
          for (int k = 0; k < n; k++) stage_win[s][k] = stage_win[s][n + k];
          stage_skipping[s] = 1'b0;
        end
        f = n;
      end
      stage_fill[s] = f;
      return;
    end
    if (f < 3 * n) begin
      stage_fill[s] = f;
      return;
    end
    clean = 1'b1;
    same = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (stage_win[s][k] == SPACE_CP) clean = 1'b0;
      if (stage_win[s][k] >= DIGIT_LO && stage_win[s][k] <= DIGIT_HI) clean = 1'b0;
      if (stage_win[s][k] != stage_win[s][n + k]) same = 1'b0;
      if (stage_win[s][k] != stage_win[s][2 * n + k]) same = 1'b0;
    end
    if (clean && same) begin
      stage_fill[s] = n;
      stage_skipping[s] = 1'b1;
      for (int k = 0; k < 2 * n; k++) stage_feed(s + 1, stage_win[s][k]);
    end else begin
      x = stage_win[s][0];
      for (int k = 0; k < f - 1; k++) stage_win[s][k] = stage_win[s][k + 1];
      stage_fill[s] = f - 1;
      stage_feed(s + 1, x);
    end
  endfunction

  // Works out the result items caused by one accepted character.
  function automatic void predict_char(logic [CPW-1:0] c, logic eos);
    int f, first;
    if (!string_open) begin
      rep_latched = rep_enable_q;
      string_open = 1'b1;
    end
    if (kept_chars < max_chars_q) begin
      kept_chars++;
      if (rep_latched) stage_feed(0, c);
      else separator_feed(c);
    end
    if (eos) begin
      // End of string: every stage drains its window in order, skipping the
      // copy that a contracting stage still holds at its front.
      if (rep_latched) begin
        for (int s = 0; s < STAGES; s++) begin
          f = stage_fill[s];
          first = stage_skipping[s] ? s + 1 : 0;
          stage_fill[s] = 0;
          stage_skipping[s] = 1'b0;
          for (int k = first; k < f; k++) stage_feed(s + 1, stage_win[s][k]);
        end
      end
      if (held_ok) release_held(1'b0, 1'b1);
      clear_string_state();
    end
  endfunction

  // Driver: a new item may be taken from the queue once the current one has
  // gone or none is shown. The payload holds steady while the block stalls.
  always @(posedge clk) begin
    char_item_t it;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        it = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_code_point <= it.cp;
        in_end_of_string <= it.eos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction at each accepted input item.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_char(in_code_point, in_end_of_string);
  end

  // Receiver stall, random except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    logic [CPW-1:0] want_cp;
    logic           want_last;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cp.size() == 0) begin
        $error("unexpected result item: out_code_point %h out_last %b",
               out_code_point, out_last);
        error_count++;
      end else begin
        want_cp = expected_cp.pop_front();
        want_last = expected_last.pop_front();
        if (out_code_point !== want_cp) begin
          $error("out_code_point: expected %h actual %h", want_cp, out_code_point);
          error_count++;
        end
        if (out_last !== want_last) begin
          $error("out_last: expected %b actual %b", want_last, out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; the shadow copy is
  // updated at the edge where the block takes the value.
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_REP_EN:   rep_enable_q = value[0];
      REG_MASK_LO:  sep_mask_lo_q = value;
      REG_MASK_HI:  sep_mask_hi_q = value;
      REG_MAX_CHAR: max_chars_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic add_text(string txt, bit terminate);
    char_item_t it;
    for (int i = 0; i < txt.len(); i++) begin
      it.cp = CPW'(txt[i]);
      it.eos = terminate && (i == txt.len() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic add_char(logic [CPW-1:0] c, bit eos);
    char_item_t it;
    it.cp = c;
    it.eos = eos;
    pending_chars.push_back(it);
  endtask

  // Characters drawn often from a small alphabet so that repeats are common,
  // with spaces, digits, separators, non-ASCII and fully random code points.
  function automatic logic [CPW-1:0] pick_char();
    case ($urandom_range(11))
      0, 1:    return CPW'("a");
      2:       return CPW'("b");
      3:       return CPW'("c");
      4:       return SPACE_CP;
      5:       return DIGIT_LO + CPW'($urandom_range(9));
      6:       return CPW'(",");
      7:       return APOS_CP;
      8:       return CPW'(".");
      9:       return CPW'($urandom_range(127));
      10:      return CPW'($urandom_range(16'hFFFF, 128));
      default: return CPW'($urandom());
    endcase
  endfunction

  // Mostly strings built from repeated patterns; now and then pure noise.
  task automatic add_random_strings(int count);
    logic [CPW-1:0] pat[3];
    int plen, reps, len, added;
    added = 0;
    while (added < count) begin
      len = 0;
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) add_char(pick_char(), i == len - 1);
      end else begin
        while (len < 18 && ($urandom_range(3) != 0 || len == 0)) begin
          plen = $urandom_range(3, 1);
          reps = $urandom_range(6, 1);
          for (int k = 0; k < plen; k++) pat[k] = pick_char();
          for (int r = 0; r < reps; r++)
            for (int k = 0; k < plen; k++) begin
              add_char(pat[k], 1'b0);
              len++;
            end
        end
        pending_chars[$].eos = 1'b1;
      end
      added += len;
    end
  endtask

  // Waits until all items are sent and all results checked, then lets the
  // block drain any work that caused no result.
  task automatic settle();
    while (pending_chars.size() > 0 || in_valid || expected_cp.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clear_string_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: contraction on, no separators. Runs of each pattern length,
    // digits that block contraction, and the code point extremes.
    add_text("aaaaa", 1'b1);
    add_text("abababab", 1'b1);
    add_text("xyzxyzxyzx", 1'b1);
    add_text("1111", 1'b1);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h000000, 1'b1);
    // An open string is left behind so that disabling contraction must not
    // touch it: the enable was latched at its first character.
    add_text("qqq", 1'b0);
    settle();
    write_reg(REG_REP_EN, 64'd0);
    add_text("q", 1'b1);
    settle();

    // Separators: comma, period, apostrophe, tilde, at sign and the space bit,
    // which must be ignored. Covers separators at both ends and next to spaces.
    write_reg(REG_MASK_LO, (64'd1 << 8'h2C) | (64'd1 << 8'h2E) | (64'd1 << 8'h27)
                           | (64'd1 << 8'h20));
    write_reg(REG_MASK_HI, (64'd1 << (8'h7E - 64)) | (64'd1 << (8'h40 - 64)));
    write_reg(REG_REP_EN, 64'd1);
    add_text(",a, b'c ~.", 1'b1);
    add_text("@", 1'b1);
    add_random_strings(120);
    settle();

    // Shortest strings: one character kept, the rest dropped, and the mark
    // on a dropped character still ends the string.
    write_reg(REG_MAX_CHAR, 64'd1);
    add_text("hello", 1'b1);
    calm = 1'b1;
    add_random_strings(60);
    settle();
    calm = 1'b0;

    // Contraction off, every ASCII code but space a separator, short truncation.
    write_reg(REG_REP_EN, 64'd0);
    write_reg(REG_MASK_LO, '1);
    write_reg(REG_MASK_HI, '1);
    write_reg(REG_MAX_CHAR, 64'd5);
    add_random_strings(80);
    settle();

    // Random masks, contraction on, longest setting then a mid-size one.
    write_reg(REG_REP_EN, 64'd1);
    write_reg(REG_MASK_LO, {$urandom(), $urandom()});
    write_reg(REG_MASK_HI, {$urandom(), $urandom()});
    write_reg(REG_MAX_CHAR, 64'hFFFF);
    add_random_strings(80);
    settle();
    write_reg(REG_MAX_CHAR, 64'($urandom_range(30, 3)));
    add_random_strings(60);
    settle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
